// ===== hdl/lsnr_pkg.sv =====
// Shared types and constants of the lidar scan nearest-angle resampler.
// No dependencies; imported by the front, queue, back and top modules.
`timescale 1ns / 1ps
`default_nettype none
package lsnr_pkg;

  localparam int CFG_IDX_W   = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [15:0] Q_ONE = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_START    = 4'd0,
    REG_ANGLE_STEP     = 4'd1,
    REG_RAW_COUNT      = 4'd2,
    REG_REVERSE_ORDER  = 4'd3,
    REG_MOUNT_YAW      = 4'd4,
    REG_RANGE_LIMIT_MM = 4'd5,
    REG_HALF_VIEW      = 4'd6,
    REG_BEAM_COUNT     = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] angle_start;
    logic [31:0] angle_step;
    logic [15:0] raw_count;
    logic        reverse_order;
    logic [31:0] mount_yaw;
    logic [15:0] lim;
    logic [30:0] half_view;
    logic [6:0]  bm1;
  } cfg_t;

  typedef struct packed {
    logic [31:0] angle;
    logic [15:0] range_mm;
    logic        carries;
    logic        eos;
  } item_t;

endpackage
`default_nettype wire

// ===== hdl/lsnr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lsnr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ===== hdl/lsnr_div.sv =====
// Restoring divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lsnr_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [32:0] dividend,
  input  wire logic [16:0] divisor,
  output logic             done,
  output logic      [32:0] quotient,
  output logic      [16:0] remainder
);
  logic [32:0] quo_r, quo_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [16:0] dv_r, dv_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [17:0] sh;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {rem_r, quo_r[32]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dv_nxt   = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, dv_r}) begin
        rem_nxt = 17'(sh - {1'b0, dv_r});
        quo_nxt = {quo_r[31:0], 1'b1};
      end else begin
        rem_nxt = sh[16:0];
        quo_nxt = {quo_r[31:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd32) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;
endmodule
`default_nettype wire

// ===== hdl/lsnr_fifo.sv =====
// Short item queue between front and back.
// Depends on lsnr_pkg (item_t, QUEUE_DEPTH).
`timescale 1ns / 1ps
`default_nettype none
module lsnr_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire lsnr_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output lsnr_pkg::item_t     pop_item,
  output logic                not_empty
);
  import lsnr_pkg::*;
  localparam int AW = $clog2(QUEUE_DEPTH);

  item_t        buf_r [QUEUE_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) buf_r[wp_r] <= push_item;
  end

  assign full      = (cnt_r == (AW+1)'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_item  = buf_r[rp_r];
endmodule
`default_nettype wire

// ===== hdl/lsnr_front.sv =====
// Front: accepts input beats, tracks the sample index, computes the
// base-frame angle and clamped range, and queues the item. Uses lsnr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lsnr_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire lsnr_pkg::cfg_t  cfg,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [15:0]     in_range_mm,
  input  wire logic            in_no_echo,
  input  wire logic            in_carries_sample,
  input  wire logic            in_end_of_scan,
  output logic                 q_push,
  output lsnr_pkg::item_t      q_item,
  input  wire logic            q_full
);
  import lsnr_pkg::*;

  logic [15:0] sidx_r;
  logic        s1_v_r;
  logic [31:0] s1_idx_r;
  logic [15:0] s1_rng_r;
  logic        s1_car_r, s1_eos_r;
  logic        acc;
  logic [31:0] idx;
  logic [15:0] rng;
  logic [31:0] prod;

  assign q_push   = s1_v_r && !q_full;
  assign in_ready = !s1_v_r || !q_full;
  assign acc      = in_valid && in_ready;

  assign idx = cfg.reverse_order ? (32'(cfg.raw_count) - 32'd1 - 32'(sidx_r))
                                 : 32'(sidx_r);
  assign rng = (in_no_echo || in_range_mm > cfg.lim) ? cfg.lim : in_range_mm;
  assign prod = 32'(s1_idx_r * cfg.angle_step);

  always_comb begin
    q_item.angle    = cfg.angle_start + prod + cfg.mount_yaw;
    q_item.range_mm = s1_rng_r;
    q_item.carries  = s1_car_r;
    q_item.eos      = s1_eos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sidx_r <= '0;
      s1_v_r <= 1'b0;
    end else begin
      if (q_push) s1_v_r <= 1'b0;
      if (acc && (in_carries_sample || in_end_of_scan)) s1_v_r <= 1'b1;
      if (acc && in_end_of_scan) begin
        sidx_r <= '0;
      end else if (acc && in_carries_sample && sidx_r != 16'hFFFF) begin
        sidx_r <= sidx_r + 16'd1;
      end
    end
    if (acc) begin
      s1_idx_r <= idx;
      s1_rng_r <= rng;
      s1_car_r <= in_carries_sample;
      s1_eos_r <= in_end_of_scan;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/lsnr_back.sv =====
// Back: recomputes target spacing, walks all target beams per sample and
// emits normalized ranges at end of scan. Uses lsnr_pkg, lsnr_ram, lsnr_div.
`timescale 1ns / 1ps
`default_nettype none
module lsnr_back #(
  parameter int MAX_BEAMS  = 64,
  parameter int ANGLE_BITS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire lsnr_pkg::cfg_t cfg,
  input  wire logic           cfg_recalc,
  input  wire logic           q_valid,
  input  wire lsnr_pkg::item_t q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [5:0]          out_beam_index,
  output logic [15:0]         out_beam_range,
  output logic                out_last_beam
);
  import lsnr_pkg::*;
  localparam int KW = $clog2(MAX_BEAMS);
  localparam int RW = ANGLE_BITS + 16;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_TGT      = 7'b0000010,
    S_WALK     = 7'b0000100,
    S_EMIT_RD  = 7'b0001000,
    S_EMIT_CHK = 7'b0010000,
    S_EMIT_DIV = 7'b0100000,
    S_EMIT_OUT = 7'b1000000
  } bst_t;

  bst_t st_r, st_nxt;
  logic        recalc_r;
  logic [31:0] tq_r, tq_nxt;
  logic [6:0]  trem_r, trem_nxt;
  logic [31:0] off_r, off_nxt;
  logic [6:0]  racc_r, racc_nxt;
  logic [KW-1:0] ik_r, ik_nxt, p_k_r, p_k_nxt, ek_r, ek_nxt;
  logic        iss_r, iss_nxt, p_v_r, p_v_nxt, out_v_r, out_v_nxt;
  logic [31:0] p_tgt_r, p_tgt_nxt, ang_r, ang_nxt;
  logic [15:0] rng_r, rng_nxt, oq_r, oq_nxt;
  logic        eos_r, eos_nxt;
  logic [MAX_BEAMS-1:0] vld_r, vld_nxt;

  logic [KW-1:0] rd_addr;
  logic [RW-1:0] rd_data;
  logic          wr_en;
  logic [ANGLE_BITS-1:0] rd_dist, dk;
  logic [15:0]   rd_rng, r_cl;
  logic [31:0]   tgt, diff, dabs;
  logic [7:0]    sum8;
  logic          wrap;
  logic          div_start, div_done;
  logic [32:0]   div_a, div_q;
  logic [16:0]   div_d, div_r;

  assign rd_dist = rd_data[RW-1:16];
  assign rd_rng  = rd_data[15:0];
  assign r_cl    = (rd_rng > cfg.lim) ? cfg.lim : rd_rng;

  assign tgt  = off_r - {1'b0, cfg.half_view};
  assign sum8 = {1'b0, racc_r} + {1'b0, trem_r};
  assign wrap = sum8 >= {1'b0, cfg.bm1};

  assign diff = ang_r - p_tgt_r;
  assign dabs = diff[31] ? (32'd0 - diff) : diff;
  assign dk   = dabs[31 -: ANGLE_BITS];
  assign wr_en = (st_r == S_WALK) && p_v_r && (!vld_r[p_k_r] || dk < rd_dist);

  assign div_a = (st_r == S_IDLE) ? {1'b0, cfg.half_view, 1'b0}
                                  : ({1'b0, r_cl, 16'd0} + {17'd0, cfg.lim});
  assign div_d = (st_r == S_IDLE) ? {10'd0, cfg.bm1} : {cfg.lim, 1'b0};

  always_comb begin
    st_nxt    = st_r;
    tq_nxt    = tq_r;
    trem_nxt  = trem_r;
    off_nxt   = off_r;
    racc_nxt  = racc_r;
    ik_nxt    = ik_r;
    iss_nxt   = iss_r;
    p_v_nxt   = 1'b0;
    p_k_nxt   = p_k_r;
    p_tgt_nxt = p_tgt_r;
    ang_nxt   = ang_r;
    rng_nxt   = rng_r;
    eos_nxt   = eos_r;
    ek_nxt    = ek_r;
    oq_nxt    = oq_r;
    out_v_nxt = out_v_r;
    vld_nxt   = vld_r;
    rd_addr   = ek_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (recalc_r) begin
          div_start = 1'b1;
          st_nxt    = S_TGT;
        end else if (q_valid) begin
          q_pop   = 1'b1;
          ang_nxt = q_item.angle;
          rng_nxt = q_item.range_mm;
          eos_nxt = q_item.eos;
          ek_nxt  = '0;
          if (q_item.carries) begin
            off_nxt  = '0;
            racc_nxt = '0;
            ik_nxt   = '0;
            iss_nxt  = 1'b1;
            st_nxt   = S_WALK;
          end else begin
            st_nxt = S_EMIT_RD;
          end
        end
      end
      S_TGT: begin
        if (div_done) begin
          tq_nxt   = div_q[31:0];
          trem_nxt = div_r[6:0];
          st_nxt   = S_IDLE;
        end
      end
      S_WALK: begin
        rd_addr = ik_r;
        if (iss_r) begin
          p_v_nxt   = 1'b1;
          p_k_nxt   = ik_r;
          p_tgt_nxt = tgt;
          racc_nxt  = wrap ? 7'(sum8 - {1'b0, cfg.bm1}) : sum8[6:0];
          off_nxt   = off_r + tq_r + 32'(wrap);
          if (7'(ik_r) == cfg.bm1) iss_nxt = 1'b0;
          else ik_nxt = ik_r + 1'b1;
        end
        if (wr_en) vld_nxt[p_k_r] = 1'b1;
        if (p_v_r && 7'(p_k_r) == cfg.bm1) begin
          p_v_nxt = 1'b0;
          st_nxt  = eos_r ? S_EMIT_RD : S_IDLE;
        end
      end
      S_EMIT_RD: st_nxt = S_EMIT_CHK;
      S_EMIT_CHK: begin
        if (vld_r[ek_r]) begin
          div_start = 1'b1;
          st_nxt    = S_EMIT_DIV;
        end else begin
          oq_nxt    = Q_ONE;
          out_v_nxt = 1'b1;
          st_nxt    = S_EMIT_OUT;
        end
      end
      S_EMIT_DIV: begin
        if (div_done) begin
          oq_nxt    = div_q[15:0];
          out_v_nxt = 1'b1;
          st_nxt    = S_EMIT_OUT;
        end
      end
      S_EMIT_OUT: begin
        if (out_ready) begin
          out_v_nxt = 1'b0;
          if (7'(ek_r) == cfg.bm1) begin
            vld_nxt = '0;
            st_nxt  = S_IDLE;
          end else begin
            ek_nxt = ek_r + 1'b1;
            st_nxt = S_EMIT_RD;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      recalc_r <= 1'b1;
      iss_r    <= 1'b0;
      p_v_r    <= 1'b0;
      out_v_r  <= 1'b0;
      vld_r    <= '0;
    end else begin
      st_r     <= st_nxt;
      recalc_r <= cfg_recalc || (recalc_r && !(st_r == S_IDLE && div_start));
      iss_r    <= iss_nxt;
      p_v_r    <= p_v_nxt;
      out_v_r  <= out_v_nxt;
      vld_r    <= vld_nxt;
    end
    tq_r    <= tq_nxt;
    trem_r  <= trem_nxt;
    off_r   <= off_nxt;
    racc_r  <= racc_nxt;
    ik_r    <= ik_nxt;
    p_k_r   <= p_k_nxt;
    p_tgt_r <= p_tgt_nxt;
    ang_r   <= ang_nxt;
    rng_r   <= rng_nxt;
    eos_r   <= eos_nxt;
    ek_r    <= ek_nxt;
    oq_r    <= oq_nxt;
  end

  lsnr_ram #(.WIDTH(RW), .DEPTH(MAX_BEAMS)) u_best (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (p_k_r),
    .wr_data ({dk, rng_r}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lsnr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_d),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign out_valid      = out_v_r;
  assign out_beam_index = 6'(ek_r);
  assign out_beam_range = oq_r;
  assign out_last_beam  = (7'(ek_r) == cfg.bm1);

  a_out_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> st_r == S_EMIT_OUT) else $error("result valid outside emit");
  a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EMIT_OUT && out_ready && 7'(ek_r) == cfg.bm1) |=> vld_r == '0)
    else $error("beam state not cleared at end of scan");
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == S_TGT || st_r == S_EMIT_DIV))
    else $error("divider result with no consumer");
endmodule
`default_nettype wire

// ===== hdl/lidar_scan_nearest_resampler_top.sv =====
// Top level of the lidar scan nearest-angle resampler: configuration
// registers, front, queue and back. Uses lsnr_pkg and all lsnr_* modules.
//
// Each sample beat makes the back visit every target beam once through
// the beam store. An end of scan emits one result per target beam. A
// matched beam goes through store read and check, a wait on the shared
// divider, and the output beat; an unmatched beam skips the divider.
// Output stalls can hold either. After reset, and after a write to
// half_view or beam_count, the target spacing is recomputed before the
// next queued beat is taken. A four-entry queue lets input beats be
// accepted while the back works.
`timescale 1ns / 1ps
`default_nettype none
module lidar_scan_nearest_resampler_top #(
  parameter int MAX_BEAMS  = 64,
  parameter int ANGLE_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lsnr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                     cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [15:0]                     in_range_mm,
  input  wire logic                            in_no_echo,
  input  wire logic                            in_carries_sample,
  input  wire logic                            in_end_of_scan,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [5:0]                           out_beam_index,
  output logic [15:0]                          out_beam_range,
  output logic                                 out_last_beam
);
  import lsnr_pkg::*;

  logic signed [31:0] angle_start_r, angle_step_r, mount_yaw_r;
  logic [15:0] raw_count_r, range_limit_r;
  logic        reverse_r;
  logic [30:0] half_view_r;
  logic [6:0]  beam_count_r, beams;
  logic        wr, recalc;
  cfg_t        cfg;
  logic        q_push, q_full, q_pop, q_valid;
  item_t       q_in, q_out;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;
  assign recalc    = wr && (cfg_index == REG_HALF_VIEW || cfg_index == REG_BEAM_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_start_r <= '0;
      angle_step_r  <= '0;
      raw_count_r   <= '0;
      reverse_r     <= 1'b0;
      mount_yaw_r   <= '0;
      range_limit_r <= 16'd10000;
      half_view_r   <= 31'h4000_0000;
      beam_count_r  <= 7'd20;
    end else if (wr) begin
      unique case (cfg_index)
        REG_ANGLE_START:    angle_start_r <= cfg_data;
        REG_ANGLE_STEP:     angle_step_r  <= cfg_data;
        REG_RAW_COUNT:      raw_count_r   <= cfg_data[15:0];
        REG_REVERSE_ORDER:  reverse_r     <= cfg_data[0];
        REG_MOUNT_YAW:      mount_yaw_r   <= cfg_data;
        REG_RANGE_LIMIT_MM: range_limit_r <= cfg_data[15:0];
        REG_HALF_VIEW:      half_view_r   <= cfg_data[30:0];
        REG_BEAM_COUNT:     beam_count_r  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (beam_count_r < 7'd2) beams = 7'd2;
    else if (beam_count_r > 7'(MAX_BEAMS)) beams = 7'(MAX_BEAMS);
    else beams = beam_count_r;
    cfg.angle_start   = angle_start_r;
    cfg.angle_step    = angle_step_r;
    cfg.raw_count     = raw_count_r;
    cfg.reverse_order = reverse_r;
    cfg.mount_yaw     = mount_yaw_r;
    cfg.lim           = (range_limit_r == 16'd0) ? 16'd1 : range_limit_r;
    cfg.half_view     = half_view_r;
    cfg.bm1           = beams - 7'd1;
  end

  lsnr_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_range_mm       (in_range_mm),
    .in_no_echo        (in_no_echo),
    .in_carries_sample (in_carries_sample),
    .in_end_of_scan    (in_end_of_scan),
    .q_push            (q_push),
    .q_item            (q_in),
    .q_full            (q_full)
  );

  lsnr_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out),
    .not_empty (q_valid)
  );

  lsnr_back #(.MAX_BEAMS(MAX_BEAMS), .ANGLE_BITS(ANGLE_BITS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cfg_recalc     (recalc),
    .q_valid        (q_valid),
    .q_item         (q_out),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_beam_index (out_beam_index),
    .out_beam_range (out_beam_range),
    .out_last_beam  (out_last_beam)
  );
endmodule
`default_nettype wire
